// ===== hdl/pal_pkg.sv =====
// shared types and constants of the positional array list
package pal_pkg;

   // request kinds as carried on req_type
   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_DELETE = 2'd1,
      REQ_UPDATE = 2'd2,
      REQ_DUMP   = 2'd3
   } req_kind_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_BADPOS = 2'd1,
      STATUS_FULL   = 2'd2,
      STATUS_EMPTY  = 2'd3
   } status_type;

   // operation that every cell of the chain applies
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_WRITE,
      CELL_ROTATE
   } cell_op_type;

   // controller state
   typedef enum logic {
      ST_IDLE,
      ST_DUMP
   } pal_state_type;

   // command broadcast to all cells
   typedef struct packed {
      cell_op_type        op;
      logic [6:0]         pos;
      logic [6:0]         count;
      logic signed [31:0] value;
   } cell_ctl_type;

endpackage

// ===== hdl/pal_cell.sv =====
// one list entry: holds a value and trades it with its neighbors
module pal_cell #(
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  pal_pkg::cell_ctl_type ctl,
   input  logic signed [31:0]    left_value,
   input  logic signed [31:0]    right_value,
   input  logic signed [31:0]    head_value,
   output logic signed [31:0]    cell_value
);
   import pal_pkg::*;

   localparam logic [6:0] IDX      = 7'(INDEX);
   localparam logic [6:0] IDX_NEXT = 7'(INDEX + 1);

   logic signed [31:0] data_ff;
   logic signed [31:0] data_in;

   // choose the next content from the broadcast command
   always_comb begin
      data_in = data_ff;
      unique case (ctl.op)
         CELL_INSERT: begin
            if (IDX > ctl.pos) begin
               data_in = left_value;
            end else if (IDX == ctl.pos) begin
               data_in = ctl.value;
            end
         end
         CELL_DELETE: begin
            if (IDX >= ctl.pos) begin
               data_in = right_value;
            end
         end
         CELL_WRITE: begin
            if (IDX == ctl.pos) begin
               data_in = ctl.value;
            end
         end
         CELL_ROTATE: begin
            if (IDX_NEXT == ctl.count) begin
               data_in = head_value;
            end else if (IDX_NEXT < ctl.count) begin
               data_in = right_value;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   // entry storage
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign cell_value = data_ff;

endmodule

// ===== hdl/pal_ctrl.sv =====
// request decode, element count, dump sequencing and result register
module pal_ctrl #(
   parameter int DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_type,
   input  logic [6:0]            req_position,
   input  logic signed [31:0]    req_write_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_status,
   output logic signed [31:0]    rsp_read_value,
   output logic [5:0]            rsp_read_index,
   output logic [6:0]            rsp_element_count,
   output logic                  rsp_last,
   input  logic signed [31:0]    head_value,
   output pal_pkg::cell_ctl_type cell_ctl
);
   import pal_pkg::*;

   localparam logic [6:0] DEPTH_C = 7'(DEPTH);

   pal_state_type      state_ff, state_in;
   logic [6:0]         count_ff, count_in;
   logic [5:0]         idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         status_ff, status_in;
   logic signed [31:0] value_ff, value_in;
   logic [5:0]         index_ff, index_in;
   logic [6:0]         elems_ff, elems_in;
   logic               last_ff, last_in;

   logic               slot_free;
   logic               accept;
   logic               load;
   logic               dump_last;
   req_kind_type       kind;

   assign kind      = req_kind_type'(req_type);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !slot_free;
   assign accept    = req_valid && !req_stall;
   assign dump_last = ({1'b0, idx_ff} + 7'd1) == count_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && kind == REQ_DUMP && count_ff != 7'd0) begin
               state_in = ST_DUMP;
            end
         end
         ST_DUMP: begin
            if (slot_free && dump_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // cell commands, count update and result beat
   always_comb begin
      count_in       = count_ff;
      idx_in         = idx_ff;
      load           = 1'b0;
      status_in      = STATUS_OK;
      value_in       = '0;
      index_in       = '0;
      last_in        = 1'b1;
      cell_ctl.op    = CELL_HOLD;
      cell_ctl.pos   = req_position;
      cell_ctl.count = count_ff;
      cell_ctl.value = req_write_value;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in = '0;
               unique case (kind)
                  REQ_INSERT: begin
                     load = 1'b1;
                     if (req_position > count_ff) begin
                        status_in = STATUS_BADPOS;
                     end else if (count_ff == DEPTH_C) begin
                        status_in = STATUS_FULL;
                     end else begin
                        cell_ctl.op = CELL_INSERT;
                        count_in    = count_ff + 7'd1;
                     end
                  end
                  REQ_DELETE: begin
                     load = 1'b1;
                     if (req_position >= count_ff) begin
                        status_in = STATUS_BADPOS;
                     end else begin
                        cell_ctl.op = CELL_DELETE;
                        count_in    = count_ff - 7'd1;
                     end
                  end
                  REQ_UPDATE: begin
                     load = 1'b1;
                     if (req_position >= count_ff) begin
                        status_in = STATUS_BADPOS;
                     end else begin
                        cell_ctl.op = CELL_WRITE;
                     end
                  end
                  REQ_DUMP: begin
                     if (count_ff == 7'd0) begin
                        load      = 1'b1;
                        status_in = STATUS_EMPTY;
                     end
                  end
                  default: begin
                     load = 1'b0;
                  end
               endcase
            end
         end
         ST_DUMP: begin
            // emit the head entry and rotate the occupied part of the chain
            if (slot_free) begin
               load        = 1'b1;
               value_in    = head_value;
               index_in    = idx_ff;
               last_in     = dump_last;
               cell_ctl.op = CELL_ROTATE;
               idx_in      = idx_ff + 6'd1;
            end
         end
         default: begin
            load = 1'b0;
         end
      endcase
      elems_in = count_in;
   end

   // result valid follows load and downstream take
   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= status_in;
         value_ff  <= value_in;
         index_ff  <= index_in;
         elems_ff  <= elems_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_read_value    = value_ff;
   assign rsp_read_index    = index_ff;
   assign rsp_element_count = elems_ff;
   assign rsp_last          = last_ff;

`ifndef NO_ASSERTIONS
   // element count stays within the store
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("element count above depth");

   // dump index never runs past the list
   a_dump_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DUMP |-> {1'b0, idx_ff} < count_ff)
      else $error("dump index beyond count");

   // an insert, delete or update request gives a final beat in the next cycle
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      accept && kind != REQ_DUMP |=> rsp_valid_ff && last_ff)
      else $error("missing result for request");

   // empty status only with an empty list
   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == STATUS_EMPTY |-> elems_ff == 7'd0 && last_ff)
      else $error("empty status with elements present");
`endif

endmodule

// ===== hdl/positional_array_list_top.sv =====
// top level of the positional array list: controller plus a chain of entry cells
// Each list entry lives in a cell of a chain of DEPTH cells, so insert, delete
// and update move or write every affected entry at once: such a request's one
// result is registered and appears in the cycle after it is taken, giving one
// request per cycle while results are taken. A dump streams the list by
// rotating the occupied cells past cell 0, one element a beat, and holds off
// further requests until its last beat is loaded, also while the result side
// stalls (an empty list gives its one beat like any other request). Results
// sit in an output register; requests are held off while it is full and stalled.
module positional_array_list_top #(
   parameter int DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic [6:0]         req_position,
   input  logic signed [31:0] req_write_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_read_value,
   output logic [5:0]         rsp_read_index,
   output logic [6:0]         rsp_element_count,
   output logic               rsp_last
);
   import pal_pkg::*;

   cell_ctl_type       cell_ctl;
   logic signed [31:0] cell_q [DEPTH];

   // request decode and result register
   pal_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_position      (req_position),
      .req_write_value   (req_write_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_read_value    (rsp_read_value),
      .rsp_read_index    (rsp_read_index),
      .rsp_element_count (rsp_element_count),
      .rsp_last          (rsp_last),
      .head_value        (cell_q[0]),
      .cell_ctl          (cell_ctl)
   );

   // chain of entry cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [31:0] left_w;
      logic signed [31:0] right_w;

      if (i == 0) begin : g_first
         assign left_w = cell_q[i];
      end else begin : g_mid_l
         assign left_w = cell_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_end
         assign right_w = cell_q[i];
      end else begin : g_mid_r
         assign right_w = cell_q[i+1];
      end

      pal_cell #(
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .ctl         (cell_ctl),
         .left_value  (left_w),
         .right_value (right_w),
         .head_value  (cell_q[0]),
         .cell_value  (cell_q[i])
      );
   end

endmodule
